@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by haversine_distance_core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every rising edge, skipped while reset is high
`define ASSERT_CLKD(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// Check a property on every rising edge, reset included
`define ASSERT_CLK(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLKD(lbl, clk, rst, prop)
`define ASSERT_CLK(lbl, clk, prop)
`endif
`endif

@@ design/hvd_pkg.sv @@
// ----------------------------------------------------------------------------
// hvd_pkg
// Types and constants of the haversine distance datapath.
// ----------------------------------------------------------------------------
package hvd_pkg;

   typedef logic signed [31:0] trig_type;
   typedef logic signed [33:0] wide_type;

   localparam int CORDIC_STEPS = 30;
   localparam int SQRT_STEPS   = 31;

   localparam logic [30:0] Q30_ONE         = 31'h4000_0000;
   localparam logic [33:0] CORDIC_GAIN_Q30 = 34'd652032874;
   localparam logic [31:0] DEG7_TO_BAM_MUL = 32'd2562047788;
   localparam logic [33:0] RADIUS_PI_Q20   = 34'd13040946163;
   localparam logic [21:0] MAX_DISTANCE    = 22'd3183825;

   // Quadrant codes of the rotation CORDIC
   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   // Arctangent of 2^-i in binary angle units (2^32 per turn)
   localparam logic [31:0] ATAN_BAM [0:CORDIC_STEPS-1] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

endpackage

@@ design/hvd_conv.sv @@
// ----------------------------------------------------------------------------
// hvd_conv
// Converts coordinates and their differences to binary angles in three stages.
// ----------------------------------------------------------------------------
module hvd_conv import hvd_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic signed [30:0] first_lat,
   input  logic signed [31:0] first_lon,
   input  logic signed [30:0] second_lat,
   input  logic signed [31:0] second_lon,
   output logic [31:0]        ang [0:3]
);

   logic signed [32:0] val [0:3];
   logic [31:0]        mag_ff [0:3];
   logic [31:0]        mag_in [0:3];
   logic               neg_ff [0:3];
   logic               neg2_ff [0:3];
   logic [63:0]        prod_ff [0:3];
   logic [31:0]        ang_ff [0:3];

   // Lanes: first latitude, second latitude, half latitude delta, half longitude delta
   assign val[0] = {{2{first_lat[30]}}, first_lat};
   assign val[1] = {{2{second_lat[30]}}, second_lat};
   assign val[2] = {{2{second_lat[30]}}, second_lat} - {{2{first_lat[30]}}, first_lat};
   assign val[3] = {second_lon[31], second_lon} - {first_lon[31], first_lon};

   for (genvar k = 0; k < 4; k++) begin : g_lane
      localparam int SH = (k >= 2) ? 32 : 31;
      logic [32:0] abs_w;
      logic [64:0] rnd_w;
      logic [31:0] bam_w;

      // Take the magnitude
      assign abs_w     = val[k][32] ? 33'(-val[k]) : 33'(val[k]);
      assign mag_in[k] = abs_w[31:0];

      // Round half up, keep one turn and restore the sign
      assign rnd_w = ({1'b0, prod_ff[k]} + (65'd1 << (SH - 1))) >> SH;
      assign bam_w = rnd_w[31:0];

      always_ff @(posedge clock) begin
         if (en) begin
            mag_ff[k]  <= mag_in[k];
            neg_ff[k]  <= val[k][32];
            prod_ff[k] <= mag_ff[k] * DEG7_TO_BAM_MUL;
            neg2_ff[k] <= neg_ff[k];
            ang_ff[k]  <= neg2_ff[k] ? 32'(-bam_w) : bam_w;
         end
      end

      assign ang[k] = ang_ff[k];
   end

endmodule

@@ design/hvd_sincos.sv @@
// ----------------------------------------------------------------------------
// hvd_sincos
// Rotation CORDIC: one micro-rotation a stage, quadrant fold-back at the end.
// ----------------------------------------------------------------------------
module hvd_sincos import hvd_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] ang,
   output trig_type    cos_o,
   output trig_type    sin_o
);

   wide_type x_ff [0:CORDIC_STEPS];
   wide_type y_ff [0:CORDIC_STEPS];
   wide_type z_ff [0:CORDIC_STEPS];
   quad_type q_ff [0:CORDIC_STEPS];
   trig_type cos_ff;
   trig_type sin_ff;
   trig_type cos_in;
   trig_type sin_in;

   logic [32:0] rnd_w;
   logic [2:0]  q4_w;

   // Split into nearest quadrant and residual angle
   assign rnd_w = {1'b0, ang} + 33'h0_2000_0000;
   assign q4_w  = rnd_w[32:30];

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= wide_type'(CORDIC_GAIN_Q30);
         y_ff[0] <= '0;
         z_ff[0] <= $signed({2'b00, ang}) - $signed({1'b0, q4_w, 30'b0});
         q_ff[0] <= quad_type'(q4_w[1:0]);
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      wide_type dx_w, dy_w, at_w;
      assign dx_w = y_ff[i] >>> i;
      assign dy_w = x_ff[i] >>> i;
      assign at_w = $signed({2'b00, ATAN_BAM[i]});

      // Rotate towards zero residual
      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_ff[i][33]) begin
               x_ff[i+1] <= x_ff[i] - dx_w;
               y_ff[i+1] <= y_ff[i] + dy_w;
               z_ff[i+1] <= z_ff[i] - at_w;
            end else begin
               x_ff[i+1] <= x_ff[i] + dx_w;
               y_ff[i+1] <= y_ff[i] - dy_w;
               z_ff[i+1] <= z_ff[i] + at_w;
            end
            q_ff[i+1] <= q_ff[i];
         end
      end
   end

   // Fold back into the original quadrant
   always_comb begin
      unique case (q_ff[CORDIC_STEPS])
         QUAD_0: begin
            cos_in = trig_type'(x_ff[CORDIC_STEPS]);
            sin_in = trig_type'(y_ff[CORDIC_STEPS]);
         end
         QUAD_1: begin
            cos_in = trig_type'(-y_ff[CORDIC_STEPS]);
            sin_in = trig_type'(x_ff[CORDIC_STEPS]);
         end
         QUAD_2: begin
            cos_in = trig_type'(-x_ff[CORDIC_STEPS]);
            sin_in = trig_type'(-y_ff[CORDIC_STEPS]);
         end
         default: begin
            cos_in = trig_type'(y_ff[CORDIC_STEPS]);
            sin_in = trig_type'(-x_ff[CORDIC_STEPS]);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_o = cos_ff;
   assign sin_o = sin_ff;

endmodule

@@ design/hvd_haver.sv @@
// ----------------------------------------------------------------------------
// hvd_haver
// Haversine term a and its complement 1-a, clamped to [0,1], in three stages.
// ----------------------------------------------------------------------------
module hvd_haver import hvd_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  trig_type    cos_first,
   input  trig_type    cos_second,
   input  trig_type    sin_dlat,
   input  trig_type    sin_dlon,
   output logic [30:0] hav_a,
   output logic [30:0] hav_b
);

   logic signed [63:0] pcc_w, pll_w, ppp_w, pt_w;
   trig_type           pcc_ff, pll_ff, ppp_ff, ppp2_ff, t_ff;
   logic signed [32:0] sum_w;
   logic [30:0]        a_ff, b_ff, a_in, b_in;

   assign pcc_w = cos_first * cos_second;
   assign pll_w = sin_dlon * sin_dlon;
   assign ppp_w = sin_dlat * sin_dlat;
   assign pt_w  = pcc_ff * pll_ff;
   assign sum_w = {ppp2_ff[31], ppp2_ff} + {t_ff[31], t_ff};

   // Clamp a and form the complement in parallel
   always_comb begin
      priority if (sum_w[32]) begin
         a_in = '0;
         b_in = Q30_ONE;
      end else if (sum_w > $signed({2'b00, Q30_ONE})) begin
         a_in = Q30_ONE;
         b_in = '0;
      end else begin
         a_in = sum_w[30:0];
         b_in = Q30_ONE - sum_w[30:0];
      end
   end

   // Advance products, then sum and clamp
   always_ff @(posedge clock) begin
      if (en) begin
         pcc_ff  <= pcc_w[61:30];
         pll_ff  <= pll_w[61:30];
         ppp_ff  <= ppp_w[61:30];
         t_ff    <= pt_w[61:30];
         ppp2_ff <= ppp_ff;
         a_ff    <= a_in;
         b_ff    <= b_in;
      end
   end

   assign hav_a = a_ff;
   assign hav_b = b_ff;

endmodule

@@ design/hvd_isqrt.sv @@
// ----------------------------------------------------------------------------
// hvd_isqrt
// Floor square root of value * 2^30, one root bit per stage.
// ----------------------------------------------------------------------------
module hvd_isqrt import hvd_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [30:0] value,
   output logic [30:0] root
);

   logic [32:0] rem_ff  [0:SQRT_STEPS];
   logic [30:0] root_ff [0:SQRT_STEPS];
   logic [61:0] n_ff    [0:SQRT_STEPS];

   assign rem_ff[0]  = '0;
   assign root_ff[0] = '0;
   assign n_ff[0]    = {1'b0, value, 30'b0};

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      logic [34:0] r2_w, trial_w, diff_w;
      assign r2_w    = {rem_ff[k], n_ff[k][61:60]};
      assign trial_w = {2'b00, root_ff[k], 2'b01};
      assign diff_w  = r2_w - trial_w;

      // Subtract the trial when it fits and shift in the root bit
      always_ff @(posedge clock) begin
         if (en) begin
            if (r2_w >= trial_w) begin
               rem_ff[k+1]  <= diff_w[32:0];
               root_ff[k+1] <= {root_ff[k][29:0], 1'b1};
            end else begin
               rem_ff[k+1]  <= r2_w[32:0];
               root_ff[k+1] <= {root_ff[k][29:0], 1'b0};
            end
            n_ff[k+1] <= {n_ff[k][59:0], 2'b00};
         end
      end
   end

   assign root = root_ff[SQRT_STEPS];

endmodule

@@ design/hvd_atan.sv @@
// ----------------------------------------------------------------------------
// hvd_atan
// Vectoring CORDIC for the half central angle, then scaling to distance.
// ----------------------------------------------------------------------------
module hvd_atan import hvd_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [30:0] num,
   input  logic [30:0] den,
   output logic [21:0] distance
);

   wide_type x_ff [0:CORDIC_STEPS];
   wide_type y_ff [0:CORDIC_STEPS];
   wide_type z_ff [0:CORDIC_STEPS];

   logic [30:0] theta_w;
   logic [64:0] prod_ff;
   logic [65:0] rnd_w;
   logic [21:0] dist_ff;

   assign x_ff[0] = {3'b000, den};
   assign y_ff[0] = {3'b000, num};
   assign z_ff[0] = '0;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      wide_type dx_w, dy_w, at_w;
      assign dx_w = y_ff[i] >>> i;
      assign dy_w = x_ff[i] >>> i;
      assign at_w = $signed({2'b00, ATAN_BAM[i]});

      // Rotate the vector onto the x axis
      always_ff @(posedge clock) begin
         if (en) begin
            if (!y_ff[i][33]) begin
               x_ff[i+1] <= x_ff[i] + dx_w;
               y_ff[i+1] <= y_ff[i] - dy_w;
               z_ff[i+1] <= z_ff[i] + at_w;
            end else begin
               x_ff[i+1] <= x_ff[i] - dx_w;
               y_ff[i+1] <= y_ff[i] + dy_w;
               z_ff[i+1] <= z_ff[i] - at_w;
            end
         end
      end
   end

   // Clamp the angle to a quarter turn of the half angle
   always_comb begin
      priority if (z_ff[CORDIC_STEPS][33]) begin
         theta_w = '0;
      end else if (z_ff[CORDIC_STEPS] > $signed({3'b000, Q30_ONE})) begin
         theta_w = Q30_ONE;
      end else begin
         theta_w = z_ff[CORDIC_STEPS][30:0];
      end
   end

   assign rnd_w = {1'b0, prod_ff} + (66'd1 << 41);

   // Scale by pi times radius and round
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= theta_w * RADIUS_PI_Q20;
         dist_ff <= rnd_w[63:42];
      end
   end

   assign distance = dist_ff;

endmodule

@@ design/haversine_distance_core.sv @@
// Throughput: one beat per cycle; the whole pipeline advances unless a held
// response is stalled, so the input stalls only when the output is stalled.
// Stage count: 3 conversion, 32 sine/cosine, 3 haversine, 31 root, 32 angle.
// Reset: synchronous, clears all valid bits; datapath registers are not reset.
// ----------------------------------------------------------------------------
// haversine_distance_core
// Great-circle distance between two points, fully pipelined CORDIC datapath.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module haversine_distance_core import hvd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [30:0] req_first_lat,
   input  logic signed [31:0] req_first_lon,
   input  logic signed [30:0] req_second_lat,
   input  logic signed [31:0] req_second_lon,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [21:0]        rsp_distance
);

   localparam int LAT     = 101;
   localparam int HAV_POS = 37;

   logic           en;
   logic [LAT-1:0] valid_ff;
   logic [LAT-1:0] valid_in;
   logic [31:0]    ang_w [0:3];
   trig_type       cos_first_w, cos_second_w, sin_dlat_w, sin_dlon_w;
   logic [30:0]    hav_a_w, hav_b_w, root_a_w, root_b_w;
   logic [31:0]    hav_sum_w;

   // Advance everything unless the response beat is held
   assign en        = !valid_ff[LAT-1] || !rsp_stall;
   assign req_stall = !en;
   assign valid_in  = {valid_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   hvd_conv u_conv (
      .clock      (clock),
      .en         (en),
      .first_lat  (req_first_lat),
      .first_lon  (req_first_lon),
      .second_lat (req_second_lat),
      .second_lon (req_second_lon),
      .ang        (ang_w)
   );

   hvd_sincos u_sc_lat1 (
      .clock (clock), .en (en), .ang (ang_w[0]), .cos_o (cos_first_w), .sin_o ()
   );
   hvd_sincos u_sc_lat2 (
      .clock (clock), .en (en), .ang (ang_w[1]), .cos_o (cos_second_w), .sin_o ()
   );
   hvd_sincos u_sc_dlat (
      .clock (clock), .en (en), .ang (ang_w[2]), .cos_o (), .sin_o (sin_dlat_w)
   );
   hvd_sincos u_sc_dlon (
      .clock (clock), .en (en), .ang (ang_w[3]), .cos_o (), .sin_o (sin_dlon_w)
   );

   hvd_haver u_haver (
      .clock      (clock),
      .en         (en),
      .cos_first  (cos_first_w),
      .cos_second (cos_second_w),
      .sin_dlat   (sin_dlat_w),
      .sin_dlon   (sin_dlon_w),
      .hav_a      (hav_a_w),
      .hav_b      (hav_b_w)
   );

   hvd_isqrt u_sqrt_a (.clock (clock), .en (en), .value (hav_a_w), .root (root_a_w));
   hvd_isqrt u_sqrt_b (.clock (clock), .en (en), .value (hav_b_w), .root (root_b_w));

   hvd_atan u_atan (
      .clock    (clock),
      .en       (en),
      .num      (root_a_w),
      .den      (root_b_w),
      .distance (rsp_distance)
   );

   assign rsp_valid = valid_ff[LAT-1];
   assign hav_sum_w = {1'b0, hav_a_w} + {1'b0, hav_b_w};

   // The haversine term and its complement always make one
   `ASSERT_CLKD(a_hav_sum, clock, reset, valid_ff[HAV_POS] |-> (hav_sum_w == {1'b0, Q30_ONE}))
   // A response never exceeds half the circumference
   `ASSERT_CLKD(a_dist_max, clock, reset, rsp_valid |-> (rsp_distance <= MAX_DISTANCE))
   // Reset empties the pipeline
   `ASSERT_CLK(a_reset_empty, clock, reset |=> (valid_ff == '0))

endmodule
